[design/mdtp_pkg.sv]
package mdtp_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int ARG_W          = 16;
  localparam int QDEPTH         = 4;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ARRAY = 8'h5B;
  localparam logic [7:0] CH_CLASS = 8'h4C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_VOID  = 8'h56;

  typedef struct packed {
    logic             item_kind;
    logic [7:0]       tag_char;
    logic [ARG_W-1:0] arg_number;
    logic             well_formed;
    logic             run_end;
  } res_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
    res_t d0;
    res_t d1;
  } push_t;

endpackage

[design/mdtp_if.sv]
interface mdtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       final_byte;

  modport source (output valid, output char_byte, output final_byte, input ready);
  modport sink (input valid, input char_byte, input final_byte, output ready);
endinterface

interface mdtp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  tag_char;
  logic [15:0] arg_number;
  logic        well_formed;
  logic        run_end;

  modport source (output valid, output item_kind, output tag_char, output arg_number,
                  output well_formed, output run_end, input ready);
  modport sink (input valid, input item_kind, input tag_char, input arg_number,
                input well_formed, input run_end, output ready);
endinterface

[design/method_descriptor_tag_parser.sv]
// Method descriptor tag parser.
// The input channel in_ch carries one descriptor byte per word, with
// final_byte set on the last byte. The output channel out_ch carries an
// argument word (item_kind 0) for each argument type and, on the final byte,
// a summary word (item_kind 1) with the validity flag, the argument count and
// the return tag. run_end marks the last word caused by one input byte.
// A byte accepted into the input stage register is decoded from there, and its
// words are written into the result queue, from whose head they are presented.
// The block accepts one byte every cycle while the queue has room; a byte that
// yields two words writes both into the four-word result queue together.
// The decode stage holds its byte while the queue has fewer than two free
// entries, so in_ch.ready drops only while the decode stage holds its byte.
// No word is dropped or repeated under back-pressure.
// A synchronous reset (rst_n low) empties the queue and the input stage and
// returns the parser to waiting for the opening parenthesis; it also returns
// there by itself after each final byte.
module method_descriptor_tag_parser import mdtp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mdtp_in_if.sink    in_ch,
  mdtp_out_if.source out_ch
);

  push_t push;
  logic  room;

  mdtp_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  mdtp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

[design/mdtp_core.sv]
module mdtp_core import mdtp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mdtp_in_if.sink   in_ch,
  input  logic      room,
  output push_t     push
);

  localparam logic [2:0] PH_OPEN  = 3'd0;
  localparam logic [2:0] PH_ARGS  = 3'd1;
  localparam logic [2:0] PH_ARRAY = 3'd2;
  localparam logic [2:0] PH_NAME  = 3'd3;
  localparam logic [2:0] PH_RET   = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;
  localparam logic [2:0] PH_SEEK  = 3'd6;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                  s1_valid_r;
  logic [7:0]            s1_char_r;
  logic                  s1_fin_r;
  logic                  proc;

  logic [2:0]            phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [7:0]            ret_r, ret_nxt;
  logic                  failed_r, failed_nxt;
  logic                  emit;
  logic                  ok;
  logic [7:0]            rt;
  res_t                  arg_res;
  res_t                  sum_res;

  assign in_ch.ready = !s1_valid_r || room;
  assign proc        = s1_valid_r && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (room) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_byte;
      s1_fin_r  <= in_ch.final_byte;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    total_nxt  = total_r;
    ret_nxt    = ret_r;
    failed_nxt = failed_r;
    emit       = 1'b0;
    case (phase_r)
      PH_OPEN: begin
        if (s1_char_r == CH_OPEN) begin
          phase_nxt = PH_ARGS;
        end else begin
          failed_nxt = 1'b1;
          phase_nxt  = (s1_char_r == CH_CLOSE) ? PH_RET : PH_SEEK;
        end
      end
      PH_ARGS: begin
        if (s1_char_r == CH_CLOSE) begin
          phase_nxt = PH_RET;
        end else begin
          emit = 1'b1;
          if (s1_char_r == CH_ARRAY) begin
            phase_nxt = PH_ARRAY;
          end else if (s1_char_r == CH_CLASS) begin
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_ARRAY: begin
        if (s1_char_r == CH_CLASS) begin
          phase_nxt = PH_NAME;
        end else if (s1_char_r != CH_ARRAY) begin
          phase_nxt = PH_ARGS;
        end
      end
      PH_NAME: begin
        if (s1_char_r == CH_SEMI) begin
          phase_nxt = PH_ARGS;
        end
      end
      PH_RET: begin
        ret_nxt   = s1_char_r;
        phase_nxt = PH_DONE;
      end
      PH_SEEK: begin
        if (s1_char_r == CH_CLOSE) begin
          phase_nxt = PH_RET;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
    if (emit && total_r != CNT_MAX) begin
      total_nxt = total_r + 1'b1;
    end
  end

  assign ok = !failed_nxt && (phase_nxt == PH_RET || phase_nxt == PH_DONE);
  assign rt = (phase_nxt == PH_DONE) ? ret_nxt : CH_VOID;

  assign arg_res = '{item_kind: 1'b0, tag_char: s1_char_r, arg_number: ARG_W'(total_r),
                     well_formed: 1'b0, run_end: !s1_fin_r};
  assign sum_res = '{item_kind: 1'b1, tag_char: rt, arg_number: ARG_W'(total_nxt),
                     well_formed: ok, run_end: 1'b1};

  assign push.wr0 = proc && (emit || s1_fin_r);
  assign push.wr1 = proc && emit && s1_fin_r;
  assign push.d0  = emit ? arg_res : sum_res;
  assign push.d1  = sum_res;

  // The final byte of a descriptor returns the parser to its reset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OPEN;
      total_r  <= '0;
      ret_r    <= CH_VOID;
      failed_r <= 1'b0;
    end else if (proc) begin
      if (s1_fin_r) begin
        phase_r  <= PH_OPEN;
        total_r  <= '0;
        ret_r    <= CH_VOID;
        failed_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        total_r  <= total_nxt;
        ret_r    <= ret_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

endmodule

[design/mdtp_queue.sv]
module mdtp_queue import mdtp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       room,
  mdtp_out_if.source out_ch
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  res_t          mem [QDEPTH];
  logic [PW-1:0] head_r, tail_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  res_t          head_word;

  assign pop       = (cnt_r != '0) && out_ch.ready;
  assign room      = cnt_r <= CW'(QDEPTH - 2);
  assign cnt_nxt   = cnt_r + CW'(push.wr0) + CW'(push.wr1) - CW'(pop);
  assign head_word = mem[head_r];

  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.item_kind   = head_word.item_kind;
  assign out_ch.tag_char    = head_word.tag_char;
  assign out_ch.arg_number  = head_word.arg_number;
  assign out_ch.well_formed = head_word.well_formed;
  assign out_ch.run_end     = head_word.run_end;

  always_ff @(posedge clk) begin
    if (push.wr0) begin
      mem[tail_r] <= push.d0;
    end
    if (push.wr1) begin
      mem[PW'(tail_r + 1'b1)] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        head_r <= PW'(head_r + 1'b1);
      end
      tail_r <= PW'(tail_r + PW'(push.wr0) + PW'(push.wr1));
    end
  end

endmodule

[design/mdtp_checker.sv]
module mdtp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_item_kind,
  input logic [7:0]  out_tag_char,
  input logic [15:0] out_arg_number,
  input logic        out_well_formed,
  input logic        out_run_end
);

  // A stalled word keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag_char)
      && $stable(out_arg_number) && $stable(out_item_kind) && $stable(out_run_end))
    else $error("output word changed while stalled");

  a_arg_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_kind |-> !out_well_formed)
    else $error("argument word carries a validity flag");

  a_sum_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind |-> out_run_end)
    else $error("summary word is not the last word of its byte");

  // An argument word that is not the last of its byte is followed at once by
  // the summary of the same byte.
  a_sum_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_item_kind && !out_run_end |=> out_valid && out_item_kind)
    else $error("summary word missing after argument word");

endmodule

bind method_descriptor_tag_parser mdtp_checker u_mdtp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_item_kind   (out_ch.item_kind),
  .out_tag_char    (out_ch.tag_char),
  .out_arg_number  (out_ch.arg_number),
  .out_well_formed (out_ch.well_formed),
  .out_run_end     (out_ch.run_end)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mdtp_pkg::*;

  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam logic [ARG_W-1:0] ARG_CAP = ARG_W'((1 << COUNT_BITS) - 1);
  localparam int RANDOM_BYTES = 1350;
  localparam int QUIET_AFTER = 1150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 50;

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_ARGS,
    PH_ARRAY,
    PH_NAME,
    PH_RET,
    PH_DONE,
    PH_SEEK
  } parse_phase_t;

  class tag_predictor;
    parse_phase_t phase;
    logic [ARG_W-1:0] arg_total;
    logic [7:0] ret_char;
    bit failed;
    res_t pending[$];
    int mismatches;
    int bytes_taken;
    int descriptors;
    int arg_words;
    int summary_words;

    function new();
      restart();
    endfunction

    function void restart();
      phase = PH_OPEN;
      arg_total = '0;
      ret_char = CH_VOID;
      failed = 1'b0;
    endfunction

    function void push_arg(logic [7:0] tag, bit fin);
      res_t w;
      w.item_kind = 1'b0;
      w.tag_char = tag;
      w.arg_number = arg_total;
      w.well_formed = 1'b0;
      w.run_end = !fin;
      pending.push_back(w);
      if (arg_total != ARG_CAP) begin
        arg_total++;
      end
    endfunction

    function void take_byte(logic [7:0] c, bit fin);
      res_t w;
      bytes_taken++;
      case (phase)
        PH_OPEN: begin
          if (c == CH_OPEN) begin
            phase = PH_ARGS;
          end else begin
            failed = 1'b1;
            phase = (c == CH_CLOSE) ? PH_RET : PH_SEEK;
          end
        end
        PH_ARGS: begin
          if (c == CH_CLOSE) begin
            phase = PH_RET;
          end else begin
            push_arg(c, fin);
            if (c == CH_ARRAY) begin
              phase = PH_ARRAY;
            end else if (c == CH_CLASS) begin
              phase = PH_NAME;
            end
          end
        end
        PH_ARRAY: begin
          if (c == CH_CLASS) begin
            phase = PH_NAME;
          end else if (c != CH_ARRAY) begin
            phase = PH_ARGS;
          end
        end
        PH_NAME: begin
          if (c == CH_SEMI) begin
            phase = PH_ARGS;
          end
        end
        PH_RET: begin
          ret_char = c;
          phase = PH_DONE;
        end
        PH_SEEK: begin
          if (c == CH_CLOSE) begin
            phase = PH_RET;
          end
        end
        default: begin
          phase = PH_DONE;
        end
      endcase
      if (fin) begin
        w.item_kind = 1'b1;
        w.tag_char = (phase == PH_DONE) ? ret_char : CH_VOID;
        w.arg_number = arg_total;
        w.well_formed = !failed && (phase == PH_RET || phase == PH_DONE);
        w.run_end = 1'b1;
        pending.push_back(w);
        descriptors++;
        restart();
      end
    endfunction

    task report_mismatch(string what, res_t got, res_t want);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
        $display({"[%0t] %s: got kind %0b tag %02h num %0d ok %0b end %0b, ",
                  "wanted kind %0b tag %02h num %0d ok %0b end %0b"},
                 $realtime, what, got.item_kind, got.tag_char, got.arg_number,
                 got.well_formed, got.run_end, want.item_kind, want.tag_char,
                 want.arg_number, want.well_formed, want.run_end);
      end
    endtask

    task check_word(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report_mismatch("word with nothing pending", got, got);
        return;
      end
      want = pending.pop_front();
      if (want.item_kind) begin
        summary_words++;
      end else begin
        arg_words++;
      end
      if (got.item_kind !== want.item_kind) begin
        report_mismatch("item_kind", got, want);
      end
      if (got.tag_char !== want.tag_char) begin
        report_mismatch("tag_char", got, want);
      end
      if (got.arg_number !== want.arg_number) begin
        report_mismatch("arg_number", got, want);
      end
      if (got.well_formed !== want.well_formed) begin
        report_mismatch("well_formed", got, want);
      end
      if (got.run_end !== want.run_end) begin
        report_mismatch("run_end", got, want);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit gaps_on = 1'b1;
  int cycles = 0;
  logic [7:0] desc_bytes[$];
  tag_predictor tags = new();

  mdtp_in_if in_ch();
  mdtp_out_if out_ch();

  method_descriptor_tag_parser #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words pending.", cycles, tags.pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.item_kind = out_ch.item_kind;
      got.tag_char = out_ch.tag_char;
      got.arg_number = out_ch.arg_number;
      got.well_formed = out_ch.well_formed;
      got.run_end = out_ch.run_end;
      tags.check_word(got);
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic [7:0] c, bit fin);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_byte <= c;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    tags.take_byte(c, fin);
  endtask

  task automatic send_desc();
    foreach (desc_bytes[i]) begin
      send_word(desc_bytes[i], i == desc_bytes.size() - 1);
    end
    desc_bytes.delete();
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (tags.pending.size() != 0) @(posedge clk);
  endtask

  // Anything that ARGS reads as a single-byte argument.
  function automatic logic [7:0] plain_char();
    string prims;
    logic [7:0] c;
    prims = "BCDFIJSZ";
    if ($urandom_range(0, 1) == 0) begin
      return prims[$urandom_range(0, 7)];
    end
    do c = 8'($urandom_range(0, 255));
    while (c == CH_CLOSE || c == CH_ARRAY || c == CH_CLASS);
    return c;
  endfunction

  function automatic void add_class_name();
    logic [7:0] c;
    desc_bytes.push_back(CH_CLASS);
    repeat ($urandom_range(0, 5)) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_SEMI);
      desc_bytes.push_back(c);
    end
    desc_bytes.push_back(CH_SEMI);
  endfunction

  function automatic void add_arg_type();
    case ($urandom_range(0, 5))
      0: add_class_name();
      1: begin
        repeat ($urandom_range(1, 3)) desc_bytes.push_back(CH_ARRAY);
        case ($urandom_range(0, 3))
          0: add_class_name();
          1: desc_bytes.push_back(CH_CLOSE);
          default: desc_bytes.push_back(plain_char());
        endcase
      end
      default: desc_bytes.push_back(plain_char());
    endcase
  endfunction

  function automatic void build_good_desc();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    desc_bytes.push_back(CH_OPEN);
    repeat (n) add_arg_type();
    desc_bytes.push_back(CH_CLOSE);
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        desc_bytes.push_back(plain_char());
        repeat ($urandom_range(1, 3)) desc_bytes.push_back(8'($urandom_range(0, 255)));
      end
      2, 3, 4: desc_bytes.push_back(CH_VOID);
      default: desc_bytes.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void build_bad_desc();
    logic [7:0] specials[6];
    int keep;
    specials = '{CH_OPEN, CH_CLOSE, CH_ARRAY, CH_CLASS, CH_SEMI, CH_VOID};
    case ($urandom_range(0, 2))
      0: begin
        build_good_desc();
        keep = $urandom_range(1, desc_bytes.size());
        while (desc_bytes.size() > keep) void'(desc_bytes.pop_back());
      end
      1: begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 1) == 0) begin
            desc_bytes.push_back(specials[$urandom_range(0, 5)]);
          end else begin
            desc_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
      default: begin
        build_good_desc();
        desc_bytes[0] = 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.char_byte <= 8'h00;
    in_ch.final_byte <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Nested arrays, an array of a class whose name holds a close paren, zero and
    // all-ones arguments, a close paren as array element, then bytes after the return tag.
    desc_bytes = '{CH_OPEN, CH_ARRAY, CH_ARRAY, CH_CLASS, CH_CLOSE, CH_SEMI, 8'h00, 8'hFF,
                   CH_ARRAY, CH_CLOSE, CH_CLOSE, CH_VOID, 8'h5A};
    send_desc();
    desc_bytes = '{CH_CLOSE, 8'h4A};
    send_desc();
    desc_bytes = '{8'h58, CH_CLOSE};
    send_desc();
    desc_bytes = '{CH_OPEN, CH_CLASS};
    send_desc();
    desc_bytes = '{CH_OPEN};
    send_desc();
    desc_bytes = '{CH_OPEN, CH_CLOSE};
    send_desc();
    desc_bytes = '{CH_OPEN, CH_ARRAY};
    send_desc();
    drain_results();

    while (tags.bytes_taken < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) begin
        build_bad_desc();
      end else begin
        build_good_desc();
      end
      send_desc();
      if (tags.bytes_taken >= RANDOM_BYTES / 2 && tags.bytes_taken < RANDOM_BYTES / 2 + 20) begin
        drain_results();
      end
      if (tags.bytes_taken >= QUIET_AFTER) begin
        gaps_on = 1'b0;
      end
    end

    drain_results();
    repeat (10) @(posedge clk);

    $display("Checked %0d descriptors from %0d bytes: %0d argument words, %0d summary words.",
             tags.descriptors, tags.bytes_taken, tags.arg_words, tags.summary_words);
    $display("Mix of well-formed, truncated and garbled input with stalls on both sides.");
    if (tags.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found.", tags.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/mdtp_pkg.sv
design/mdtp_if.sv
design/mdtp_core.sv
design/mdtp_queue.sv
design/method_descriptor_tag_parser.sv
design/mdtp_checker.sv
tb/testbench.sv
